FILE: hw/rtl/cct_pkg.sv
// shared types and constants for the client connection table
`timescale 1ns / 1ps

package cct_pkg;

  // table size and derived widths
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 16;
  localparam int DESC_W      = 16;
  localparam int REQ_W       = 32;
  localparam int COUNT_OUT_W = 5;

  // operation codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_INSERT       = 3'd0,
    MODE_DELETE       = 3'd1,
    MODE_EXISTS       = 3'd2,
    MODE_SET_REQ_PAIR = 3'd3,
    MODE_SET_REQ_DESC = 3'd4,
    MODE_SET_DESC     = 3'd5
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_e;

  // table update commands
  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_INSERT   = 2'd1,
    OP_DELETE   = 2'd2,
    OP_SET_DESC = 2'd3
  } op_e;

  // input beat
  typedef struct packed {
    logic [2:0]              mode;
    logic [ADDR_W-1:0]       client_addr;
    logic [PORT_W-1:0]       client_port;
    logic [DESC_W-1:0]       descriptor;
    logic signed [REQ_W-1:0] request_code;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [1:0]             status;
    logic                   found;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_item_t;

  // stored table contents as seen by the compare logic
  typedef logic [TABLE_DEPTH-1:0]             valid_vec_t;
  typedef logic [TABLE_DEPTH-1:0][ADDR_W-1:0] addr_vec_t;
  typedef logic [TABLE_DEPTH-1:0][PORT_W-1:0] port_vec_t;
  typedef logic [TABLE_DEPTH-1:0][DESC_W-1:0] desc_vec_t;

  // compare results
  typedef struct packed {
    valid_vec_t       pair_hit;
    logic             pair_any;
    logic [IDX_W-1:0] pair_idx;
    logic             desc_any;
    logic [IDX_W-1:0] desc_idx;
    logic             free_any;
    logic [IDX_W-1:0] free_idx;
  } match_t;

  // table update command
  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [DESC_W-1:0] desc;
  } update_t;

endpackage

FILE: hw/rtl/client_connection_table.sv
// top level of the client connection table: beat registers and operation decode
//
// Fully associative table of TABLE_DEPTH client slots keyed by (address, port).
// Input channel in_valid / in_stall / in_data carries one operation per beat:
// insert, delete, exists query, set request code by pair or by descriptor,
// set descriptor by pair. Each accepted beat gives exactly one result beat on
// out_valid / out_stall / out_data with a status, a found flag and the entry
// count after the operation. Request codes have no read path here, so a set
// request only reports whether the addressed slot exists.
// A beat accepted into the input register moves on to out_data when the result register
// takes it, which a held result on out_stall can delay.
// Throughput: one beat per cycle while out_stall is low; the key is compared against
// every slot in parallel in the cycle between the input register and the result
// register, and the table update lands on the same edge as the result.
// Reset (rst_n low, synchronous) empties the table and both beat registers
// at once; no clearing pass is needed and in_stall is low straight after.
// When out_stall holds a result, the input register keeps its beat and
// in_stall rises, so nothing is lost or repeated.
`timescale 1ns / 1ps

module client_connection_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cct_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cct_pkg::out_item_t out_data
);
  import cct_pkg::*;

  logic       in_valid_r;
  logic       in_valid_nxt;
  in_item_t   in_data_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_data_r;
  out_item_t  result;
  logic       advance;
  logic       in_take;
  match_t     match;
  update_t    upd;
  update_t    upd_req;
  valid_vec_t entry_valid;
  valid_vec_t desc_valid;
  addr_vec_t  entry_addr;
  port_vec_t  entry_port;
  desc_vec_t  entry_desc;
  logic [CNT_W-1:0] count_nxt;

  // beat flow between the two registers
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    priority if (in_take) in_valid_nxt = 1'b1;
    else if (advance)     in_valid_nxt = 1'b0;
    else                  in_valid_nxt = in_valid_r;
  end

  always_comb begin
    priority if (advance) out_valid_nxt = 1'b1;
    else if (!out_stall)  out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  // key compare
  cct_match u_match (
    .item        (in_data_r),
    .entry_valid (entry_valid),
    .desc_valid  (desc_valid),
    .entry_addr  (entry_addr),
    .entry_port  (entry_port),
    .entry_desc  (entry_desc),
    .match       (match)
  );

  // operation decode
  always_comb begin
    result.status      = ST_NOT_FOUND;
    result.found       = 1'b0;
    upd_req.op         = OP_NONE;
    upd_req.idx        = match.pair_idx;
    upd_req.addr       = in_data_r.client_addr;
    upd_req.port       = in_data_r.client_port;
    upd_req.desc       = in_data_r.descriptor;
    unique case (in_data_r.mode)
      MODE_INSERT: begin
        priority if (match.pair_any) begin
          result.status = ST_DUPLICATE;
          result.found  = 1'b1;
        end else if (match.free_any) begin
          result.status = ST_OK;
          upd_req.op    = OP_INSERT;
          upd_req.idx   = match.free_idx;
        end else begin
          result.status = ST_FULL;
        end
      end
      MODE_DELETE: begin
        if (match.pair_any) begin
          result.status = ST_OK;
          result.found  = 1'b1;
          upd_req.op    = OP_DELETE;
        end
      end
      MODE_EXISTS: begin
        result.status = ST_OK;
        result.found  = match.pair_any;
      end
      MODE_SET_REQ_PAIR: begin
        if (match.pair_any) begin
          result.status = ST_OK;
          result.found  = 1'b1;
        end
      end
      MODE_SET_REQ_DESC: begin
        if (match.desc_any) begin
          result.status = ST_OK;
          result.found  = 1'b1;
        end
      end
      MODE_SET_DESC: begin
        if (match.pair_any) begin
          result.status = ST_OK;
          result.found  = 1'b1;
          upd_req.op    = OP_SET_DESC;
        end
      end
      default: ;
    endcase
    result.entry_count = COUNT_OUT_W'(count_nxt);
  end

  // table changes only when the beat moves on
  always_comb begin
    upd = upd_req;
    if (!advance) begin
      upd.op = OP_NONE;
    end
  end

  // slot storage
  cct_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (upd),
    .entry_valid (entry_valid),
    .desc_valid  (desc_valid),
    .entry_addr  (entry_addr),
    .entry_port  (entry_port),
    .entry_desc  (entry_desc),
    .count_nxt   (count_nxt)
  );

  // a pair lives in at most one slot
  a_pair_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match.pair_hit))
    else $error("pair held in more than one slot");

  // a full report means every slot was taken
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == ST_FULL) |->
      out_data_r.entry_count == COUNT_OUT_W'(TABLE_DEPTH))
    else $error("full reported with free slots");

  // a held result blocks the input stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && out_stall |-> in_stall && !advance)
    else $error("input stage moved while result was held");

endmodule

FILE: hw/rtl/cct_match.sv
// parallel key compare and lowest-index select over all table slots
`timescale 1ns / 1ps

module cct_match (
  input  cct_pkg::in_item_t   item,
  input  cct_pkg::valid_vec_t entry_valid,
  input  cct_pkg::valid_vec_t desc_valid,
  input  cct_pkg::addr_vec_t  entry_addr,
  input  cct_pkg::port_vec_t  entry_port,
  input  cct_pkg::desc_vec_t  entry_desc,
  output cct_pkg::match_t     match
);
  import cct_pkg::*;

  valid_vec_t pair_hit;
  valid_vec_t desc_hit;

  // per-slot compares
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pair_hit[i] = entry_valid[i] && (entry_addr[i] == item.client_addr) &&
                    (entry_port[i] == item.client_port);
      desc_hit[i] = entry_valid[i] && desc_valid[i] && (entry_desc[i] == item.descriptor);
    end
  end

  // lowest-index pick for each vector
  always_comb begin
    match          = '0;
    match.pair_hit = pair_hit;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (pair_hit[i]) begin
        match.pair_any = 1'b1;
        match.pair_idx = IDX_W'(i);
      end
      if (desc_hit[i]) begin
        match.desc_any = 1'b1;
        match.desc_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        match.free_any = 1'b1;
        match.free_idx = IDX_W'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/cct_store.sv
// slot registers, valid bits and entry count of the connection table
`timescale 1ns / 1ps

module cct_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cct_pkg::update_t            upd,
  output cct_pkg::valid_vec_t         entry_valid,
  output cct_pkg::valid_vec_t         desc_valid,
  output cct_pkg::addr_vec_t          entry_addr,
  output cct_pkg::port_vec_t          entry_port,
  output cct_pkg::desc_vec_t          entry_desc,
  output logic [cct_pkg::CNT_W-1:0]   count_nxt
);
  import cct_pkg::*;

  valid_vec_t       entry_valid_r;
  valid_vec_t       desc_valid_r;
  addr_vec_t        entry_addr_r;
  port_vec_t        entry_port_r;
  desc_vec_t        entry_desc_r;
  logic [CNT_W-1:0] valid_total_r;

  // count after the pending update
  always_comb begin
    unique case (upd.op)
      OP_INSERT: count_nxt = valid_total_r + CNT_W'(1);
      OP_DELETE: count_nxt = valid_total_r - CNT_W'(1);
      default:   count_nxt = valid_total_r;
    endcase
  end

  // control state: valid bits and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      desc_valid_r  <= '0;
      valid_total_r <= '0;
    end else begin
      valid_total_r <= count_nxt;
      unique case (upd.op)
        OP_INSERT: begin
          entry_valid_r[upd.idx] <= 1'b1;
          desc_valid_r[upd.idx]  <= 1'b0;
        end
        OP_DELETE: begin
          entry_valid_r[upd.idx] <= 1'b0;
          desc_valid_r[upd.idx]  <= 1'b0;
        end
        OP_SET_DESC: desc_valid_r[upd.idx] <= 1'b1;
        default: ;
      endcase
    end
  end

  // slot payload, no reset
  always_ff @(posedge clk) begin
    if (upd.op == OP_INSERT) begin
      entry_addr_r[upd.idx] <= upd.addr;
      entry_port_r[upd.idx] <= upd.port;
    end
    if (upd.op == OP_SET_DESC) begin
      entry_desc_r[upd.idx] <= upd.desc;
    end
  end

  assign entry_valid = entry_valid_r;
  assign desc_valid  = desc_valid_r;
  assign entry_addr  = entry_addr_r;
  assign entry_port  = entry_port_r;
  assign entry_desc  = entry_desc_r;

  // count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    valid_total_r == CNT_W'($countones(entry_valid_r)))
    else $error("entry count out of step with valid bits");

  // a descriptor is only marked on a live slot
  a_desc_on_live: assert property (@(posedge clk) disable iff (!rst_n)
    (desc_valid_r & ~entry_valid_r) == '0)
    else $error("descriptor marked on a free slot");

  // an insert always lands in a free slot
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    upd.op == OP_INSERT |-> !entry_valid_r[upd.idx])
    else $error("insert into an occupied slot");

endmodule

FILE: test/client_connection_table_check.sv
// checker for the connection table: keeps its own copy of the table and compares every result beat
`timescale 1ns / 1ps

module client_connection_table_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  cct_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  cct_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 ok_total,
  output int                 miss_total,
  output int                 full_total,
  output int                 dup_total
);
  import cct_pkg::*;

  // shadow copy of the table
  logic              slot_used    [TABLE_DEPTH];
  logic [ADDR_W-1:0] slot_addr    [TABLE_DEPTH];
  logic [PORT_W-1:0] slot_port    [TABLE_DEPTH];
  logic              slot_fd_set  [TABLE_DEPTH];
  logic [DESC_W-1:0] slot_fd      [TABLE_DEPTH];
  logic [REQ_W-1:0]  slot_request [TABLE_DEPTH];
  int                live_slots;

  // results still owed by the block, oldest first
  out_item_t         owed_results[$];
  int                mismatches = 0;
  int                status_seen [4] = '{0, 0, 0, 0};

  // lowest valid slot holding the pair, or -1
  function automatic int find_pair(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot_used[i] && slot_addr[i] == addr && slot_port[i] == port) return i;
    return -1;
  endfunction

  // apply one operation to the shadow table and work out its result
  function automatic out_item_t apply_operation(in_item_t op);
    out_item_t res;
    int        hit;
    int        slot;
    res.status = ST_NOT_FOUND;
    res.found  = 1'b0;
    hit  = find_pair(op.client_addr, op.client_port);
    slot = -1;
    case (op.mode)
      MODE_INSERT: begin
        if (hit >= 0) begin
          res.status = ST_DUPLICATE;
          res.found  = 1'b1;
        end else begin
          // lowest free slot wins
          for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
          if (slot < 0) begin
            res.status = ST_FULL;
          end else begin
            slot_used[slot]    = 1'b1;
            slot_addr[slot]    = op.client_addr;
            slot_port[slot]    = op.client_port;
            slot_fd[slot]      = '0;
            slot_fd_set[slot]  = 1'b0;
            slot_request[slot] = '0;
            live_slots++;
            res.status = ST_OK;
          end
        end
      end
      MODE_DELETE: begin
        if (hit >= 0) begin
          slot_used[hit]   = 1'b0;
          slot_fd_set[hit] = 1'b0;
          live_slots--;
          res.status = ST_OK;
          res.found  = 1'b1;
        end
      end
      MODE_EXISTS: begin
        res.status = ST_OK;
        res.found  = (hit >= 0);
      end
      MODE_SET_REQ_PAIR: begin
        if (hit >= 0) begin
          slot_request[hit] = op.request_code;
          res.status = ST_OK;
          res.found  = 1'b1;
        end
      end
      MODE_SET_REQ_DESC: begin
        // only slots with a descriptor take part, lowest index first
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
          if (slot_used[i] && slot_fd_set[i] && slot_fd[i] == op.descriptor) slot = i;
        if (slot >= 0) begin
          slot_request[slot] = op.request_code;
          res.status = ST_OK;
          res.found  = 1'b1;
        end
      end
      MODE_SET_DESC: begin
        if (hit >= 0) begin
          slot_fd[hit]     = op.descriptor;
          slot_fd_set[hit] = 1'b1;
          res.status = ST_OK;
          res.found  = 1'b1;
        end
      end
      default: ;
    endcase
    res.entry_count = COUNT_OUT_W'(live_slots);
    return res;
  endfunction

  // count a failure and print it
  task automatic flag_error(string text);
    mismatches++;
    $display("%0t: %s", $time, text);
  endtask

  // watch both channels at every edge
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_used[i]   = 1'b0;
        slot_fd_set[i] = 1'b0;
      end
      live_slots = 0;
      owed_results.delete();
    end else begin
      // accepted input beat: predict its result
      if (in_valid && !in_stall) begin
        want = apply_operation(in_data);
        owed_results.push_back(want);
        status_seen[want.status]++;
      end
      // accepted result beat: check against the oldest prediction
      if (out_valid && !out_stall) begin
        got = out_data;
        if (owed_results.size() == 0) begin
          flag_error($sformatf("unexpected result beat, got status %0d found %0d count %0d",
                               got.status, got.found, got.entry_count));
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status)
            flag_error($sformatf("status mismatch, expected %0d, got %0d",
                                 want.status, got.status));
          if (got.found !== want.found)
            flag_error($sformatf("found mismatch, expected %0d, got %0d",
                                 want.found, got.found));
          if (got.entry_count !== want.entry_count)
            flag_error($sformatf("entry_count mismatch, expected %0d, got %0d",
                                 want.entry_count, got.entry_count));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= owed_results.size();
    ok_total   <= status_seen[ST_OK];
    miss_total <= status_seen[ST_NOT_FOUND];
    full_total <= status_seen[ST_FULL];
    dup_total  <= status_seen[ST_DUPLICATE];
  end

endmodule

FILE: test/client_connection_table_test.sv
// testbench top: drives table operations into the connection table and gives the verdict
`timescale 1ns / 1ps

module client_connection_table_test;
  import cct_pkg::*;

  // spare mode codes that the block must ignore
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam int QUIET_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int BEATS_PER_HALF = 72;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int ok_total;
  int miss_total;
  int full_total;
  int dup_total;

  // idling plan per phase: none, sender, receiver, both
  int idle_plan  [4] = '{0, 54, 0, 18};
  int stall_plan [4] = '{0, 0, 54, 18};
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  // small key pools so that lookups hit and the table fills
  logic [ADDR_W-1:0] pool_addr [6];
  logic [PORT_W-1:0] pool_port [4];
  logic [DESC_W-1:0] pool_desc [5];

  client_connection_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  client_connection_table_check check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .ok_total   (ok_total),
    .miss_total (miss_total),
    .full_total (full_total),
    .dup_total  (dup_total)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // give up when nothing moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("client_connection_table regression: fail");
    $finish;
  end

  function automatic in_item_t make_op(logic [2:0] mode, logic [ADDR_W-1:0] addr,
                                       logic [PORT_W-1:0] port, logic [DESC_W-1:0] fd,
                                       logic [REQ_W-1:0] req);
    in_item_t op;
    op.mode         = mode;
    op.client_addr  = addr;
    op.client_port  = port;
    op.descriptor   = fd;
    op.request_code = req;
    return op;
  endfunction

  // random operation; fill leans towards inserts, otherwise towards deletes
  function automatic in_item_t random_op(bit fill);
    in_item_t op;
    int       roll;
    int       ins_end;
    roll    = $urandom_range(99);
    ins_end = fill ? 48 : 18;
    if (roll < 3)            op.mode = roll[0] ? MODE_SPARE_7 : MODE_SPARE_6;
    else if (roll < ins_end) op.mode = MODE_INSERT;
    else if (roll < 58)      op.mode = MODE_DELETE;
    else if (roll < 71)      op.mode = MODE_EXISTS;
    else if (roll < 81)      op.mode = MODE_SET_REQ_PAIR;
    else if (roll < 91)      op.mode = MODE_SET_REQ_DESC;
    else                     op.mode = MODE_SET_DESC;
    // mostly pooled keys, some noise
    if ($urandom_range(99) < 8) begin
      op.client_addr = $urandom();
      op.client_port = PORT_W'($urandom_range(16'hffff));
    end else begin
      op.client_addr = pool_addr[$urandom_range(5)];
      op.client_port = pool_port[$urandom_range(3)];
    end
    if ($urandom_range(99) < 10) op.descriptor = DESC_W'($urandom_range(16'hffff));
    else                         op.descriptor = pool_desc[$urandom_range(4)];
    op.request_code = $urandom();
    return op;
  endfunction

  // present one beat, honouring the sender idle rate, and hold it until taken
  task automatic send_op(in_item_t op);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // stimulus and verdict
  initial begin
    for (int i = 0; i < 6; i++) pool_addr[i] = $urandom();
    for (int i = 0; i < 4; i++) pool_port[i] = PORT_W'($urandom_range(16'hffff));
    for (int i = 0; i < 5; i++) pool_desc[i] = DESC_W'($urandom_range(16'hffff));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: every lookup misses
    send_op(make_op(MODE_EXISTS, '0, '0, '0, '0));
    send_op(make_op(MODE_DELETE, '0, '0, '0, '0));
    send_op(make_op(MODE_SET_REQ_PAIR, '0, '0, '0, 32'h7fffffff));
    send_op(make_op(MODE_SET_REQ_DESC, '0, '0, '0, 32'h80000000));
    send_op(make_op(MODE_SET_DESC, '0, '0, 16'hffff, '0));
    // inserts at the key extremes, same address on two ports, then a duplicate
    send_op(make_op(MODE_INSERT, '0, '0, '0, '0));
    send_op(make_op(MODE_INSERT, '1, '1, '1, '1));
    send_op(make_op(MODE_INSERT, '0, '1, '0, '0));
    send_op(make_op(MODE_INSERT, '0, '0, '1, '1));
    send_op(make_op(MODE_EXISTS, '1, '1, '0, '0));
    send_op(make_op(MODE_EXISTS, '1, '0, '0, '0));
    send_op(make_op(MODE_SET_REQ_PAIR, '0, '0, '0, 32'h80000000));
    send_op(make_op(MODE_SET_REQ_PAIR, '1, '1, '0, 32'h7fffffff));
    // descriptor zero is not set yet on any slot
    send_op(make_op(MODE_SET_REQ_DESC, '0, '0, '0, '1));
    // two slots share a descriptor; only the found flag is checked, not which slot is picked
    send_op(make_op(MODE_SET_DESC, '0, '1, '1, '0));
    send_op(make_op(MODE_SET_DESC, '1, '1, '1, '0));
    send_op(make_op(MODE_SET_REQ_DESC, '0, '0, '1, '1));
    send_op(make_op(MODE_SET_DESC, '0, '0, '0, '0));
    send_op(make_op(MODE_SET_REQ_DESC, '0, '0, '0, 32'h12345678));
    // delete needs the port to match as well as the address
    send_op(make_op(MODE_DELETE, '0, 16'h1234, '0, '0));
    send_op(make_op(MODE_DELETE, '0, '0, '0, '0));
    // reused slot starts with no descriptor
    send_op(make_op(MODE_INSERT, 32'h1, 16'h1, '0, '0));
    send_op(make_op(MODE_SET_REQ_DESC, '0, '0, '0, '0));
    send_op(make_op(MODE_SPARE_6, '0, '1, '0, '0));
    send_op(make_op(MODE_SPARE_7, '1, '1, '1, '1));

    // random part: each idling phase fills the table then drains it
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_plan[ph];
      stall_pct <= stall_plan[ph];
      for (int half = 0; half < 2; half++)
        for (int n = 0; n < BEATS_PER_HALF; n++)
          send_op(random_op(half == 0));
    end

    // let the last results come out
    in_valid <= 1'b0;
    stall_pct <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operations: %0d ok, %0d not found, %0d full, %0d duplicate",
             sent, ok_total, miss_total, full_total, dup_total);
    $display("idling: none, sender 54%%, receiver 54%%, both 18%%; table filled and drained");
    if (fail_count == 0 && pending == 0) begin
      $display("client_connection_table regression: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("client_connection_table regression: fail");
    end
    $finish;
  end

endmodule
